/* hdl/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define ADSR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("adsr check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define ADSR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("adsr check failed");

`endif

/* hdl/adsr_pkg.sv */
`default_nettype none

package adsr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_WAVE_SHAPE    = 3'd0,
        CFG_ATTACK_BEATS  = 3'd1,
        CFG_DECAY_BEATS   = 3'd2,
        CFG_SUSTAIN_LEVEL = 3'd3,
        CFG_RELEASE_BEATS = 3'd4,
        CFG_PULSE_WIDTH   = 3'd5,
        CFG_DETUNE_FACTOR = 3'd6,
        CFG_OCTAVE_FACTOR = 3'd7
    } t_cfg_idx;

    // oscillator shapes
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } t_wave;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [9:0] DIV12_MUL = 10'd683;
    localparam logic [4:0] OCT_BIAS  = 5'd11;
    localparam int unsigned DIV_STEPS = 17;

    // envelope sideband that rides along the divider
    typedef struct packed {
        logic        use_div;
        logic        sub_one;
        logic [16:0] const_lvl;
    } t_env_side;

    // sine evaluation context
    typedef struct packed {
        logic        [15:0] z;
        logic               neg;
        logic               is_sine;
        logic signed [15:0] alt;
    } t_osc_ctx;

    // 220 Hz times 2^(r/12), Q.16
    function automatic logic [24:0] pitch_base(input logic [3:0] r);
        logic [24:0] v;
        case (r)
            4'd0:    v = 25'd14417920;
            4'd1:    v = 25'd15275260;
            4'd2:    v = 25'd16183640;
            4'd3:    v = 25'd17145920;
            4'd4:    v = 25'd18165400;
            4'd5:    v = 25'd19245600;
            4'd6:    v = 25'd20390040;
            4'd7:    v = 25'd21602460;
            4'd8:    v = 25'd22887040;
            4'd9:    v = 25'd24247960;
            4'd10:   v = 25'd25689840;
            4'd11:   v = 25'd27217300;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/adsr_voice_sample.sv */
// throughput: one word per cycle while the output is not stalled; the 17-stage restoring
//   divider and the four-multiply sine stages are all fully pipelined
// reset: synchronous active low; clears valid bits and loads register defaults
// a stalled output freezes the whole pipe, nothing is dropped or repeated
`default_nettype none

module adsr_voice_sample #(
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // configuration
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_idx,
    input  wire  [15:0]        i_cfg_data,
    // input words
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [31:0]        i_time_seconds,
    input  wire  [7:0]         i_note_number,
    input  wire  [31:0]        i_begin_beats,
    input  wire  [31:0]        i_end_beats,
    input  wire                i_note_held,
    // result words
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [15:0] o_sample_out,
    output logic [15:0]        o_env_level,
    output logic               o_voice_active
);

    localparam int SINE_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam int NSTAGE    = 25;
    localparam int DSTEPS    = adsr_pkg::DIV_STEPS;

    // mask that keeps the sine table index bits of the phase
    localparam logic [31:0] PHASE_MASK = {32{1'b1}} << (32 - SINE_BITS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]  r_wave_shape;
    logic [15:0] r_attack_beats;
    logic [15:0] r_decay_beats;
    logic [15:0] r_sustain_level;
    logic [15:0] r_release_beats;
    logic [15:0] r_pulse_width;
    logic [15:0] r_detune_factor;
    logic [15:0] r_octave_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape    <= adsr_pkg::WAVE_SINE;
            r_attack_beats  <= 16'd64;
            r_decay_beats   <= 16'd64;
            r_sustain_level <= 16'd45875;
            r_release_beats <= 16'd64;
            r_pulse_width   <= 16'd32768;
            r_detune_factor <= 16'd256;
            r_octave_factor <= 16'd256;
        end else if (i_cfg_we) begin
            case (adsr_pkg::t_cfg_idx'(i_cfg_idx))
                adsr_pkg::CFG_WAVE_SHAPE:    r_wave_shape    <= i_cfg_data[1:0];
                adsr_pkg::CFG_ATTACK_BEATS:  r_attack_beats  <= i_cfg_data;
                adsr_pkg::CFG_DECAY_BEATS:   r_decay_beats   <= i_cfg_data;
                adsr_pkg::CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_data;
                adsr_pkg::CFG_RELEASE_BEATS: r_release_beats <= i_cfg_data;
                adsr_pkg::CFG_PULSE_WIDTH:   r_pulse_width   <= i_cfg_data;
                adsr_pkg::CFG_DETUNE_FACTOR: r_detune_factor <= i_cfg_data;
                adsr_pkg::CFG_OCTAVE_FACTOR: r_octave_factor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // q8.8 lengths seen as q16.16
    logic [23:0] len_a, len_d, len_r;
    assign len_a = {r_attack_beats, 8'b0};
    assign len_d = {r_decay_beats, 8'b0};
    assign len_r = {r_release_beats, 8'b0};

    // ------------------------------------------------------------------
    // pipe control: the whole pipe moves as one, last stage is the output
    // ------------------------------------------------------------------
    logic [NSTAGE:1] r_vld;
    logic            en;

    assign en      = !r_vld[NSTAGE] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NSTAGE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTAGE-1:1], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: beat time = floor(1.5 * seconds), note offset, factor product
    // ------------------------------------------------------------------
    logic [31:0] r1_t, r1_begin, r1_end, r1_detoct;
    logic [32:0] r1_beat;
    logic        r1_held;
    logic [8:0]  r1_n;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t      <= i_time_seconds;
            r1_beat   <= {1'b0, i_time_seconds} + {2'b0, i_time_seconds[31:1]};
            r1_begin  <= i_begin_beats;
            r1_end    <= i_end_beats;
            r1_held   <= i_note_held;
            r1_n      <= {1'b0, i_note_number} + 9'd4;
            r1_detoct <= 32'(r_detune_factor) * 32'(r_octave_factor);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: position in note, start test, end of decay, note / 12
    // ------------------------------------------------------------------
    logic [31:0] r2_t, r2_end, r2_detoct;
    logic [32:0] r2_beat, r2_pos;
    logic [33:0] r2_rp0;
    logic        r2_held, r2_pre;
    logic [8:0]  r2_n;
    logic [4:0]  r2_qd;
    logic [18:0] div12_prod;

    // reciprocal multiply, exact for every code after the offset
    assign div12_prod = 19'(r1_n) * 19'(adsr_pkg::DIV12_MUL);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_t      <= r1_t;
            r2_end    <= r1_end;
            r2_detoct <= r1_detoct;
            r2_beat   <= r1_beat;
            r2_pos    <= r1_beat - {1'b0, r1_begin};
            r2_pre    <= r1_beat < {1'b0, r1_begin};
            r2_rp0    <= {2'b0, r1_begin} + {10'b0, len_a} + {10'b0, len_d};
            r2_held   <= r1_held;
            r2_n      <= r1_n;
            r2_qd     <= div12_prod[17:13];
        end
    end

    // ------------------------------------------------------------------
    // stage 3: attack test, release point, semitone remainder
    // ------------------------------------------------------------------
    logic [31:0] r3_t, r3_detoct;
    logic [32:0] r3_beat, r3_pos, r3_pa;
    logic [33:0] r3_rp;
    logic        r3_held, r3_pre, r3_att, r3_sus_end;
    logic [3:0]  r3_semi;
    logic [4:0]  r3_qd;
    logic [8:0]  semi_full;

    assign semi_full = r2_n - 9'(r2_qd) * 9'd12;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_t       <= r2_t;
            r3_detoct  <= r2_detoct;
            r3_beat    <= r2_beat;
            r3_pos     <= r2_pos;
            r3_pa      <= r2_pos - {9'b0, len_a};
            r3_att     <= r2_pos <= {9'b0, len_a};
            r3_rp      <= (r2_rp0 > {2'b0, r2_end}) ? r2_rp0 : {2'b0, r2_end};
            r3_sus_end <= r2_beat < {1'b0, r2_end};
            r3_held    <= r2_held;
            r3_pre     <= r2_pre;
            r3_semi    <= semi_full[3:0];
            r3_qd      <= r2_qd;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: decay test, release position, base pitch times factors
    // ------------------------------------------------------------------
    logic [31:0] r4_t;
    logic [32:0] r4_pos, r4_pa;
    logic [33:0] r4_rpos;
    logic        r4_held, r4_pre, r4_att, r4_dec, r4_sus_end;
    logic [40:0] r4_f41;
    logic [4:0]  r4_qd;
    logic [56:0] freq_prod;

    assign freq_prod = 57'(adsr_pkg::pitch_base(r3_semi)) * 57'(r3_detoct);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_t       <= r3_t;
            r4_pos     <= r3_pos;
            r4_pa      <= r3_pa;
            r4_dec     <= r3_pa <= {9'b0, len_d};
            r4_rpos    <= {1'b0, r3_beat} - r3_rp;
            r4_held    <= r3_held;
            r4_pre     <= r3_pre;
            r4_att     <= r3_att;
            r4_sus_end <= r3_sus_end;
            r4_f41     <= freq_prod[56:16];
            r4_qd      <= r3_qd;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: envelope segment select, divider operands; octave shift
    // ------------------------------------------------------------------
    logic [31:0]         r5_t, r5_f32;
    logic [23:0]         r5_mul_a, r5_den;
    logic [16:0]         r5_mul_b;
    adsr_pkg::t_env_side r5_side;

    adsr_pkg::t_env_side side5;
    logic [23:0]         mul_a5, den5;
    logic [16:0]         mul_b5;
    logic                rel5;
    logic [23:0]         rdiff5;
    logic [40:0]         f_shift;

    assign rel5   = r4_rpos < {10'b0, len_r};
    assign rdiff5 = len_r - r4_rpos[23:0];

    always_comb begin
        side5     = '0;
        mul_a5    = r4_pos[23:0];
        mul_b5    = adsr_pkg::ONE_Q16;
        den5      = len_a;
        if (r4_pre) begin
            // before start: level zero
            side5.const_lvl = '0;
        end else if (r4_att) begin
            if (len_a == '0) begin
                side5.const_lvl = adsr_pkg::ONE_Q16;
            end else begin
                side5.use_div = 1'b1;
            end
        end else if (r4_dec) begin
            side5.use_div = 1'b1;
            side5.sub_one = 1'b1;
            mul_a5        = r4_pa[23:0];
            mul_b5        = adsr_pkg::ONE_Q16 - {1'b0, r_sustain_level};
            den5          = len_d;
        end else if (r4_held || r4_sus_end) begin
            side5.const_lvl = {1'b0, r_sustain_level};
        end else if (rel5) begin
            side5.use_div = 1'b1;
            mul_a5        = rdiff5;
            mul_b5        = {1'b0, r_sustain_level};
            den5          = len_r;
        end else begin
            side5.const_lvl = '0;
        end
    end

    // octave count is (note + 4)/12 - 11, shift left or right
    always_comb begin
        if (r4_qd >= adsr_pkg::OCT_BIAS) begin
            f_shift = r4_f41 << (r4_qd - adsr_pkg::OCT_BIAS);
        end else begin
            f_shift = r4_f41 >> (adsr_pkg::OCT_BIAS - r4_qd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_t     <= r4_t;
            r5_f32   <= f_shift[31:0];
            r5_side  <= side5;
            r5_mul_a <= mul_a5;
            r5_mul_b <= mul_b5;
            r5_den   <= den5;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: dividend product, phase = low word of time * frequency
    // ------------------------------------------------------------------
    logic [39:0]         r6_num;
    logic [23:0]         r6_den;
    adsr_pkg::t_env_side r6_side;
    logic [31:0]         r6_frac;
    logic [40:0]         num_prod;
    logic [63:0]         phase_prod;

    assign num_prod   = 41'(r5_mul_a) * 41'(r5_mul_b);
    assign phase_prod = 64'(r5_t) * 64'(r5_f32);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_num  <= num_prod[39:0];
            r6_den  <= r5_den;
            r6_side <= r5_side;
            r6_frac <= phase_prod[31:0];
        end
    end

    // ------------------------------------------------------------------
    // stages 7..23: restoring divider, one quotient bit per stage
    // quotient never exceeds one in q16, so 17 bits suffice
    // ------------------------------------------------------------------
    logic [23:0]         r_dv_rem  [DSTEPS];
    logic [16:0]         r_dv_nlo  [DSTEPS];
    logic [16:0]         r_dv_quo  [DSTEPS];
    logic [23:0]         r_dv_den  [DSTEPS];
    adsr_pkg::t_env_side r_dv_side [DSTEPS];

    for (genvar k = 0; k < DSTEPS; k++) begin : g_div
        logic [23:0]         rem_in, den_in;
        logic [16:0]         nlo_in, quo_in;
        adsr_pkg::t_env_side side_in;
        logic [24:0]         trial, diff;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in  = {1'b0, r6_num[39:17]};
            assign nlo_in  = r6_num[16:0];
            assign quo_in  = '0;
            assign den_in  = r6_den;
            assign side_in = r6_side;
        end else begin : g_next
            assign rem_in  = r_dv_rem[k-1];
            assign nlo_in  = r_dv_nlo[k-1];
            assign quo_in  = r_dv_quo[k-1];
            assign den_in  = r_dv_den[k-1];
            assign side_in = r_dv_side[k-1];
        end

        assign trial = {rem_in, nlo_in[16]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[k]  <= ge ? diff[23:0] : trial[23:0];
                r_dv_nlo[k]  <= {nlo_in[15:0], 1'b0};
                r_dv_quo[k]  <= {quo_in[15:0], ge};
                r_dv_den[k]  <= den_in;
                r_dv_side[k] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 7: sine fold and the other three shapes
    // ------------------------------------------------------------------
    adsr_pkg::t_osc_ctx r7_ctx;
    adsr_pkg::t_osc_ctx ctx7;
    logic [31:0]        pm7;
    logic [15:0]        zraw7, p16;
    logic signed [17:0] tri_v;

    assign pm7   = r6_frac & PHASE_MASK;
    assign zraw7 = {1'b0, pm7[29:15]};
    assign p16   = r6_frac[31:16];

    always_comb begin
        if (p16 <= 16'd32768) begin
            tri_v = $signed({1'b0, p16, 1'b0}) - 18'sd32768;
        end else begin
            tri_v = 18'sd98304 - $signed({1'b0, p16, 1'b0});
        end
    end

    always_comb begin
        ctx7.z       = pm7[30] ? (16'd32768 - zraw7) : zraw7;
        ctx7.neg     = pm7[31];
        ctx7.is_sine = (r_wave_shape == adsr_pkg::WAVE_SINE);
        case (adsr_pkg::t_wave'(r_wave_shape))
            adsr_pkg::WAVE_SQUARE: begin
                ctx7.alt = (r6_frac < {r_pulse_width, 16'b0}) ? -16'sd32768 : 16'sd32767;
            end
            adsr_pkg::WAVE_SAW: begin
                ctx7.alt = $signed({~p16[15], p16[14:0]});
            end
            adsr_pkg::WAVE_TRIANGLE: begin
                ctx7.alt = (tri_v > 18'sd32767) ? 16'sd32767 : tri_v[15:0];
            end
            default: begin
                ctx7.alt = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_ctx <= ctx7;
        end
    end

    // ------------------------------------------------------------------
    // stages 8..11: odd polynomial z*(A - z^2*(B - z^2*C)), q15
    // ------------------------------------------------------------------
    adsr_pkg::t_osc_ctx r8_ctx, r9_ctx, r10_ctx;
    logic [15:0]        r8_z2, r9_z2, r9_y1, r10_y2;
    logic signed [15:0] r11_osc;
    logic [31:0]        sq8, m9, m10, m11;
    logic [15:0]        y11;

    assign sq8 = 32'(r7_ctx.z) * 32'(r7_ctx.z);
    assign m9  = 32'(r8_z2) * 32'(adsr_pkg::SIN_C);
    assign m10 = 32'(r9_z2) * 32'(r9_y1);
    assign m11 = 32'(r10_ctx.z) * 32'(r10_y2);
    // peak clamp
    assign y11 = (m11[31:15] > 17'd32767) ? 16'd32767 : m11[30:15];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_ctx  <= r7_ctx;
            r8_z2   <= sq8[30:15];
            r9_ctx  <= r8_ctx;
            r9_z2   <= r8_z2;
            r9_y1   <= adsr_pkg::SIN_B - m9[30:15];
            r10_ctx <= r9_ctx;
            r10_y2  <= adsr_pkg::SIN_A - m10[30:15];
            if (r10_ctx.is_sine) begin
                r11_osc <= r10_ctx.neg ? -$signed(y11) : $signed(y11);
            end else begin
                r11_osc <= r10_ctx.alt;
            end
        end
    end

    // ------------------------------------------------------------------
    // stages 12..24: oscillator delay line to meet the divider
    // ------------------------------------------------------------------
    localparam int ODLY = 13;
    logic signed [15:0] r_osc_dly [ODLY];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_osc_dly[0] <= r11_osc;
            for (int i = 1; i < ODLY; i++) begin
                r_osc_dly[i] <= r_osc_dly[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 24: envelope level, saturate one to 65535
    // ------------------------------------------------------------------
    logic [15:0]         r24_lvl;
    logic [16:0]         lvl17;
    adsr_pkg::t_env_side side_last;
    logic [16:0]         quo_last;

    assign side_last = r_dv_side[DSTEPS-1];
    assign quo_last  = r_dv_quo[DSTEPS-1];

    always_comb begin
        if (!side_last.use_div) begin
            lvl17 = side_last.const_lvl;
        end else if (side_last.sub_one) begin
            lvl17 = adsr_pkg::ONE_Q16 - quo_last;
        end else begin
            lvl17 = quo_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r24_lvl <= lvl17[16] ? 16'hFFFF : lvl17[15:0];
        end
    end

    // ------------------------------------------------------------------
    // stage 25: sample = floor(osc * level / 2) in q1.15
    // ------------------------------------------------------------------
    logic signed [32:0] out_prod;

    assign out_prod = 33'(r_osc_dly[ODLY-1]) * $signed({17'b0, r24_lvl});

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_sample_out   <= out_prod[32:17];
            o_env_level    <= r24_lvl;
            o_voice_active <= (r24_lvl != '0);
        end
    end

endmodule

`default_nettype wire

/* hdl/adsr_chk.sv */
`default_nettype none

`include "assert_macros.svh"

module adsr_chk (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_ready,
    input wire               o_valid,
    input wire               i_ready,
    input wire signed [15:0] o_sample_out,
    input wire [15:0]        o_env_level,
    input wire               o_voice_active
);

    // pipe never holds off input while the output slot is empty
    `ADSR_ASSERT_NOW(a_ready_when_empty, !o_valid, o_ready)

    // active flag follows the envelope level
    `ADSR_ASSERT_NOW(a_active_matches_env, o_valid, o_voice_active == (o_env_level != 16'd0))

    // silent envelope gives a silent sample
    `ADSR_ASSERT_NOW(a_zero_env_silent, o_valid && o_env_level == 16'd0, o_sample_out == 16'sd0)

    // stalled word holds
    `ADSR_ASSERT_NEXT(a_stall_holds, o_valid && !i_ready,
        o_valid && $stable(o_sample_out) && $stable(o_env_level))

endmodule

bind adsr_voice_sample adsr_chk u_adsr_chk (.*);

`default_nettype wire

/* dv/adsr_voice_sample_tb.sv */
`default_nettype none

module adsr_voice_sample_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SINE_DEPTH = 1024;
    localparam int PIPE_LATENCY = 25;
    localparam longint CYCLE_LIMIT = 400000;

    // one voice evaluation request
    typedef struct {
        logic [31:0] t_sec;
        logic [7:0]  note;
        logic [31:0] beg_b;
        logic [31:0] end_b;
        logic        held;
    } t_voice_req;

    // one evaluated sample
    typedef struct {
        logic signed [15:0] sample;
        logic [15:0]        env;
        logic               active;
    } t_voice_res;

    // fixed 2^(r/12) ratios, Q1.16
    localparam logic [16:0] SEMI_RATIO [12] = '{
        17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
        17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [15:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] in_time = '0;
    logic [7:0]  in_note = '0;
    logic [31:0] in_begin = '0;
    logic [31:0] in_end = '0;
    logic        in_held = 1'b0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] out_sample;
    logic [15:0]        out_env;
    logic               out_active;

    adsr_voice_sample #(.SINE_TABLE_DEPTH(SINE_DEPTH)) u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_time_seconds (in_time),
        .i_note_number  (in_note),
        .i_begin_beats  (in_begin),
        .i_end_beats    (in_end),
        .i_note_held    (in_held),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_sample_out   (out_sample),
        .o_env_level    (out_env),
        .o_voice_active (out_active)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // shadow copy of the voice registers
    adsr_pkg::t_wave shape_r;
    logic [15:0] attack_r, decay_r, sustain_r, release_r, pwidth_r, detune_r, octave_r;

    t_voice_req pending_words[$];
    t_voice_res expected_samples[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_off_cycles = 0;
    int  error_count = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    longint cycle_count = 0;

    function automatic void reset_voice_regs();
        shape_r   = adsr_pkg::WAVE_SINE;
        attack_r  = 16'd64;
        decay_r   = 16'd64;
        sustain_r = 16'd45875;
        release_r = 16'd64;
        pwidth_r  = 16'd32768;
        detune_r  = 16'd256;
        octave_r  = 16'd256;
    endfunction

    // adsr level, Q0.16 with one allowed as 65536
    function automatic longint unsigned env_level_of(longint unsigned beat,
            longint unsigned nb, longint unsigned ne, logic held);
        longint unsigned a, d, r, s, pos, lvl, rp, rpos;
        a = longint'(attack_r) << 8;
        d = longint'(decay_r) << 8;
        r = longint'(release_r) << 8;
        s = sustain_r;
        pos = beat - nb;
        if (pos <= a) begin
            if (a == 0) return 65536;
            lvl = (pos << 16) / a;
            return (lvl > 65536) ? 65536 : lvl;
        end
        if (pos - a <= d) return 65536 - ((pos - a) * (65536 - s)) / d;
        if (held || beat < ne) return s;
        rp = nb + a + d;
        if (rp < ne) rp = ne;
        rpos = beat - rp;
        if (rpos < r) return (s * (r - rpos)) / r;
        return 0;
    endfunction

    function automatic int sine_at(logic [31:0] ph);
        longint unsigned idx, p, z, z2, y;
        int quad;
        idx = (longint'(ph) * SINE_DEPTH) >> 32;
        p = (idx << 32) / SINE_DEPTH;
        quad = int'((p >> 30) & 3);
        z = (p & 64'h3FFF_FFFF) >> 15;
        if (quad & 1) z = 32768 - z;
        z2 = (z * z) >> 15;
        y = 21024 - ((z2 * 2320) >> 15);
        y = 51472 - ((z2 * y) >> 15);
        y = (z * y) >> 15;
        if (y > 32767) y = 32767;
        return (quad & 2) ? -int'(y) : int'(y);
    endfunction

    function automatic int osc_at(logic [31:0] ph);
        int p, v;
        p = int'(ph >> 16);
        case (shape_r)
            adsr_pkg::WAVE_SINE:   return sine_at(ph);
            adsr_pkg::WAVE_SQUARE: return (ph < {pwidth_r, 16'h0}) ? -32768 : 32767;
            adsr_pkg::WAVE_SAW:    return p - 32768;
            default: begin
                v = (p <= 32768) ? 2 * (p - 16384) : 2 * (49152 - p);
                return (v > 32767) ? 32767 : v;
            end
        endcase
    endfunction

    // pitch in Hz, Q.16, after the octave shift
    function automatic longint unsigned pitch_of(logic [7:0] note);
        int n, q;
        longint unsigned f;
        n = int'(note) + 4;
        q = n / 12 - 11;
        f = 64'd220 * SEMI_RATIO[n % 12];
        f = (f * detune_r * octave_r) >> 16;
        if (q >= 0) f = f << q;
        else f = f >> (-q);
        return f;
    endfunction

    function automatic t_voice_res voice_sample_of(t_voice_req w);
        t_voice_res res;
        longint unsigned beat, lvl, f;
        logic [31:0] ph;
        longint prod;
        beat = (longint'(w.t_sec) * 3) >> 1;
        res = '{16'sd0, 16'd0, 1'b0};
        if (beat < w.beg_b) return res;
        lvl = env_level_of(beat, w.beg_b, w.end_b, w.held);
        if (lvl > 65535) lvl = 65535;
        f = pitch_of(w.note);
        ph = 32'(longint'(w.t_sec) * f);
        prod = longint'(osc_at(ph)) * longint'(lvl);
        res.sample = 16'(prod >>> 17);
        res.env = 16'(lvl);
        res.active = (lvl != 0);
        return res;
    endfunction

    // driver: takes the next word when the line is free
    always @(posedge clk) begin
        logic take;
        if (rst_n) begin
            take = !in_valid || in_ready;
            if (take) begin
                if (in_valid) words_sent <= words_sent + 1;
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_voice_req w;
                    w = pending_words.pop_front();
                    expected_samples.insert(expected_samples.size(), voice_sample_of(w));
                    in_valid <= 1'b1;
                    in_time <= w.t_sec;
                    in_note <= w.note;
                    in_begin <= w.beg_b;
                    in_end <= w.end_b;
                    in_held <= w.held;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver readiness, with an optional long hold-off
    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result word with the oldest expectation
    always @(posedge clk) begin
        t_voice_res e;
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("result word with nothing expected");
                error_count <= error_count + 1;
            end else begin
                e = expected_samples.pop_front();
                words_checked <= words_checked + 1;
                if (out_sample !== e.sample) begin
                    $error("sample_out expected %0d got %0d", e.sample, out_sample);
                    error_count <= error_count + 1;
                end
                if (out_env !== e.env) begin
                    $error("env_level expected %0d got %0d", e.env, out_env);
                    error_count <= error_count + 1;
                end
                if (out_active !== e.active) begin
                    $error("voice_active expected %0d got %0d", e.active, out_active);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // run watchdog
    always @(posedge clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // one write cycle; the write enable drops again before the next write
    task automatic write_reg(adsr_pkg::t_cfg_idx idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        case (idx)
            adsr_pkg::CFG_WAVE_SHAPE:    shape_r = adsr_pkg::t_wave'(val[1:0]);
            adsr_pkg::CFG_ATTACK_BEATS:  attack_r = val;
            adsr_pkg::CFG_DECAY_BEATS:   decay_r = val;
            adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_r = val;
            adsr_pkg::CFG_RELEASE_BEATS: release_r = val;
            adsr_pkg::CFG_PULSE_WIDTH:   pwidth_r = val;
            adsr_pkg::CFG_DETUNE_FACTOR: detune_r = val;
            default:                     octave_r = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until everything sent has come back, plus pipe drain
    task automatic drain();
        while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 5) @(posedge clk);
    endtask

    function automatic void queue_word(logic [31:0] ts, logic [7:0] nt,
            logic [31:0] nb, logic [31:0] ne, logic h);
        t_voice_req w;
        w = '{ts, nt, nb, ne, h};
        pending_words.insert(pending_words.size(), w);
    endfunction

    // musically plausible word: time mostly a bit past the note start, sometimes before it
    function automatic void queue_note_word();
        logic [31:0] ts, nb, ne, beat;
        ts = $urandom_range(32'h0040_0000);
        beat = (ts * 3) >> 1;
        nb = ($urandom_range(9) == 0) ? beat + $urandom_range(65535)
                                     : beat - $urandom_range(beat < 32'h60000 ? beat : 32'h60000);
        ne = nb + $urandom_range(32'h40000);
        queue_word(ts, 8'($urandom_range(255)), nb, ne, 1'($urandom));
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                queue_word($urandom, 8'($urandom), $urandom, $urandom, 1'($urandom));
            else
                queue_note_word();
        end
    endtask

    task automatic randomize_regs();
        write_reg(adsr_pkg::CFG_WAVE_SHAPE, 16'($urandom_range(3)));
        write_reg(adsr_pkg::CFG_ATTACK_BEATS, 16'($urandom_range(1023)));
        write_reg(adsr_pkg::CFG_DECAY_BEATS, 16'($urandom_range(1023)));
        write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, 16'($urandom));
        write_reg(adsr_pkg::CFG_RELEASE_BEATS, 16'($urandom_range(1023)));
        write_reg(adsr_pkg::CFG_PULSE_WIDTH, 16'($urandom));
        write_reg(adsr_pkg::CFG_DETUNE_FACTOR, 16'($urandom_range(128, 1024)));
        write_reg(adsr_pkg::CFG_OCTAVE_FACTOR, 16'($urandom_range(64, 1024)));
    endtask

    initial begin
        reset_voice_regs();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words on reset settings: before start, field extremes
        queue_word(32'h0001_0000, 8'd128, 32'h0002_0000, 32'h0, 1'b1);
        queue_word(32'h0, 8'd0, 32'h0, 32'h0, 1'b0);
        queue_word(32'hFFFF_FFFF, 8'd255, 32'h0, 32'hFFFF_FFFF, 1'b1);
        queue_word(32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF, 32'h0, 1'b0);
        queue_word(32'h0000_8000, 8'd128, 32'h0, 32'h0, 1'b0);
        queue_word(32'h0002_0000, 8'd140, 32'h0, 32'h0001_0000, 1'b0);
        queue_word(32'h0002_0000, 8'd140, 32'h0, 32'h0001_0000, 1'b1);
        queue_word(32'h0008_0000, 8'd64, 32'h0, 32'h0010_0000, 1'b0);
        drain();

        // zero lengths, every shape, zero factors
        write_reg(adsr_pkg::CFG_ATTACK_BEATS, 16'd0);
        write_reg(adsr_pkg::CFG_DECAY_BEATS, 16'd0);
        write_reg(adsr_pkg::CFG_RELEASE_BEATS, 16'd0);
        write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, 16'hFFFF);
        write_reg(adsr_pkg::CFG_PULSE_WIDTH, 16'd0);
        for (int s = 0; s < 4; s++) begin
            write_reg(adsr_pkg::CFG_WAVE_SHAPE, 16'(s));
            queue_word(32'h0001_2345, 8'd128, 32'h0001_0000, 32'h0, 1'b0);
            queue_word(32'h0001_2345, 8'd200, 32'h0001_B468, 32'h0, 1'b0);
            queue_word(32'h0003_7777, 8'd77, 32'h0, 32'h0001_0000, 1'b1);
            drain();
        end
        write_reg(adsr_pkg::CFG_PULSE_WIDTH, 16'hFFFF);
        write_reg(adsr_pkg::CFG_DETUNE_FACTOR, 16'd0);
        queue_word(32'h0001_2345, 8'd128, 32'h0, 32'h0, 1'b1);
        drain();
        write_reg(adsr_pkg::CFG_DETUNE_FACTOR, 16'hFFFF);
        write_reg(adsr_pkg::CFG_OCTAVE_FACTOR, 16'd0);
        write_reg(adsr_pkg::CFG_SUSTAIN_LEVEL, 16'd0);
        queue_word(32'h0001_2345, 8'd255, 32'h0, 32'h0, 1'b1);
        drain();
        write_reg(adsr_pkg::CFG_OCTAVE_FACTOR, 16'hFFFF);
        write_reg(adsr_pkg::CFG_ATTACK_BEATS, 16'hFFFF);
        write_reg(adsr_pkg::CFG_DECAY_BEATS, 16'hFFFF);
        write_reg(adsr_pkg::CFG_RELEASE_BEATS, 16'hFFFF);
        queue_word(32'hFFFF_FFFF, 8'd255, 32'h0, 32'h0, 1'b0);
        queue_word(32'h7000_0000, 8'd3, 32'h0, 32'h0, 1'b0);
        drain();

        // random phases with different idling
        send_idle_pct = 8;
        recv_idle_pct = 45;
        randomize_regs();
        random_phase(130);
        drain();

        send_idle_pct = 45;
        recv_idle_pct = 8;
        randomize_regs();
        random_phase(130);
        drain();

        // no idling, and a long receiver stall to back the pipe up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        randomize_regs();
        hold_off_cycles = 200;
        random_phase(140);
        drain();

        $display("checked %0d result words from %0d sent words", words_checked, words_sent);
        $display("covered all shapes, zero and full lengths, zero factors, held and released notes");
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+hdl
hdl/adsr_pkg.sv
hdl/adsr_voice_sample.sv
hdl/adsr_chk.sv
dv/adsr_voice_sample_tb.sv
